FILE: hw/rtl/free_buffer_ring_with_phase_bit_defines.svh
// ----------------------------------------------------------------------------
// free buffer ring assertion macros
// shared property shapes for the checker
// ----------------------------------------------------------------------------
`ifndef FREE_BUFFER_RING_WITH_PHASE_BIT_DEFINES_SVH
`define FREE_BUFFER_RING_WITH_PHASE_BIT_DEFINES_SVH

// same-cycle implication, off during reset
`define FRBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define FRBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/frbp_pkg.sv
// ----------------------------------------------------------------------------
// frbp_pkg
// codes, command type and helpers for the free buffer ring
// ----------------------------------------------------------------------------
`default_nettype none

package frbp_pkg;

  localparam int COUNT_W    = 5;
  localparam int BYTES_W    = 21;
  localparam int PEER_IN_W  = 3;
  localparam int OFFSET_W   = 31;
  localparam int SLOT_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic REG_BUFFER_COUNT = 1'b0;
  localparam logic REG_BUFFER_BYTES = 1'b1;

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_TAKE    = 2'd1;
  localparam logic [1:0] OP_RETURN  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_DISABLED  = 2'd3;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_TAKE    = 2'd1;
  localparam logic [1:0] CMD_RETURN  = 2'd2;
  localparam logic [1:0] CMD_REPLY   = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          status;
    logic [PEER_IN_W-1:0] peer;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

  // ring length in use, saturated at the ring size
  function automatic logic [COUNT_W-1:0] active_len(input logic [COUNT_W-1:0] count,
                                                    input int slots);
    if (int'(count) > slots) begin
      return COUNT_W'(slots);
    end
    return count;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/frbp_queue.sv
// ----------------------------------------------------------------------------
// frbp_queue
// short command queue between the classifier and the ring engine
// ----------------------------------------------------------------------------
`default_nettype none

module frbp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  frbp_pkg::cmd_t     push_cmd,
  output logic               pop_valid,
  input  wire logic          pop,
  output frbp_pkg::cmd_t     pop_cmd
);
  import frbp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (int'(fill) < QUEUE_DEPTH);
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10: fill <= CNT_W'(fill + 1'b1);
        2'b01: fill <= CNT_W'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frbp_front.sv
// ----------------------------------------------------------------------------
// frbp_front
// classifies incoming items and settles the checks that need no ring state
// ----------------------------------------------------------------------------
`default_nettype none

module frbp_front #(
  parameter int PEERS      = 8,
  parameter int RING_SLOTS = 16
) (
  input  wire logic [1:0]                    op,
  input  wire logic [frbp_pkg::PEER_IN_W-1:0] peer,
  input  wire logic [frbp_pkg::BYTES_W-1:0]  msg_bytes,
  input  wire logic [frbp_pkg::OFFSET_W-1:0] return_offset,
  input  wire logic [frbp_pkg::COUNT_W-1:0]  buffer_count,
  input  wire logic [frbp_pkg::BYTES_W-1:0]  buffer_bytes,
  output frbp_pkg::cmd_t                     cmd
);
  import frbp_pkg::*;

  logic [COUNT_W-1:0] ring_len;

  assign ring_len = active_len(buffer_count, RING_SLOTS);

  always_comb begin
    cmd.kind   = CMD_REPLY;
    cmd.status = ST_OK;
    cmd.peer   = peer;
    cmd.offset = return_offset;
    if (int'(peer) >= PEERS) begin
      cmd.status = ST_DISABLED;
    end else begin
      case (op)
        OP_RESTART: cmd.kind = CMD_RESTART;
        OP_TAKE: begin
          if (ring_len == '0) begin
            cmd.status = ST_DISABLED;
          end else if (msg_bytes > buffer_bytes) begin
            cmd.status = ST_TOO_LARGE;
          end else begin
            cmd.kind = CMD_TAKE;
          end
        end
        OP_RETURN: begin
          if (ring_len == '0) begin
            cmd.status = ST_DISABLED;
          end else begin
            cmd.kind = CMD_RETURN;
          end
        end
        default: cmd.status = ST_OK;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/frbp_back.sv
// ----------------------------------------------------------------------------
// frbp_back
// ring engine: slot memory, per-peer indices and phases, result register
// ----------------------------------------------------------------------------
`default_nettype none

module frbp_back #(
  parameter int PEERS      = 8,
  parameter int RING_SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  frbp_pkg::cmd_t                     cmd,
  input  wire logic                          cmd_valid,
  output logic                               cmd_pop,
  input  wire logic [frbp_pkg::COUNT_W-1:0]  buffer_count,
  input  wire logic [frbp_pkg::BYTES_W-1:0]  buffer_bytes,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [frbp_pkg::OFFSET_W-1:0]      buffer_offset
);
  import frbp_pkg::*;

  localparam int PEER_W    = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int SLOT_W    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int ADDR_W    = PEER_W + SLOT_W;
  localparam int MEM_DEPTH = PEERS * (1 << SLOT_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  logic [SLOT_DATA_W-1:0] ring_mem [MEM_DEPTH];
  logic [SLOT_DATA_W-1:0] rd_data;

  logic [SLOT_W-1:0] take_index   [PEERS];
  logic [SLOT_W-1:0] return_index [PEERS];
  logic              take_phase   [PEERS];
  logic              return_phase [PEERS];

  logic [1:0]          state;
  logic [PEER_W-1:0]   cur_peer;
  logic [SLOT_W-1:0]   fill_slot;
  logic [OFFSET_W-1:0] fill_value;

  logic [COUNT_W-1:0]     ring_len;
  logic                   out_free;
  logic                   out_load;
  logic [PEER_W-1:0]      pop_peer;
  logic [SLOT_W-1:0]      ret_idx;
  logic                   ret_wrap;
  logic [SLOT_W-1:0]      ret_idx_next;
  logic [SLOT_W-1:0]      tk_idx;
  logic                   tk_wrap;
  logic [SLOT_W-1:0]      tk_idx_next;
  logic                   tk_match;
  logic                   fill_last;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [SLOT_DATA_W-1:0] mem_wdata;

  assign ring_len = active_len(buffer_count, RING_SLOTS);
  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = cmd_valid && (state == S_IDLE) && out_free;
  assign pop_peer = PEER_W'(cmd.peer);

  // index step within the active length, wrap flips the phase
  assign ret_idx      = return_index[pop_peer];
  assign ret_wrap     = !(int'(ret_idx) < int'(ring_len) - 1);
  assign ret_idx_next = ret_wrap ? '0 : SLOT_W'(ret_idx + 1'b1);

  assign tk_idx      = take_index[cur_peer];
  assign tk_wrap     = !(int'(tk_idx) < int'(ring_len) - 1);
  assign tk_idx_next = tk_wrap ? '0 : SLOT_W'(tk_idx + 1'b1);
  assign tk_match    = (rd_data[SLOT_DATA_W-1] == take_phase[cur_peer]);

  assign fill_last = !(int'(fill_slot) < int'(ring_len) - 1);

  // a result is loaded in this cycle
  always_comb begin
    case (state)
      S_IDLE: out_load = cmd_pop && (cmd.kind != CMD_TAKE) &&
                         !((cmd.kind == CMD_RESTART) && (ring_len != '0));
      S_READ: out_load = 1'b1;
      S_FILL: out_load = fill_last;
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur_peer, fill_slot};
    mem_wdata = {1'b0, fill_value};
    if (state == S_FILL) begin
      mem_we = 1'b1;
    end else if (cmd_pop && (cmd.kind == CMD_RETURN)) begin
      mem_we    = 1'b1;
      mem_waddr = {pop_peer, ret_idx};
      mem_wdata = {return_phase[pop_peer], cmd.offset};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == CMD_TAKE)) begin
      rd_data <= ring_mem[{pop_peer, take_index[pop_peer]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int p = 0; p < PEERS; p++) begin
        take_index[p]   <= '0;
        return_index[p] <= '0;
        take_phase[p]   <= 1'b0;
        return_phase[p] <= 1'b1;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            cur_peer <= pop_peer;
            case (cmd.kind)
              CMD_RESTART: begin
                take_index[pop_peer]   <= '0;
                return_index[pop_peer] <= '0;
                take_phase[pop_peer]   <= 1'b0;
                return_phase[pop_peer] <= 1'b1;
                fill_slot              <= '0;
                fill_value             <= '0;
                if (ring_len == '0) begin
                  status        <= ST_OK;
                  buffer_offset <= '0;
                end else begin
                  state <= S_FILL;
                end
              end
              CMD_TAKE: state <= S_READ;
              CMD_RETURN: begin
                return_index[pop_peer] <= ret_idx_next;
                if (ret_wrap) begin
                  return_phase[pop_peer] <= !return_phase[pop_peer];
                end
                status        <= ST_OK;
                buffer_offset <= '0;
              end
              default: begin
                status        <= cmd.status;
                buffer_offset <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_IDLE;
          if (tk_match) begin
            status                <= ST_OK;
            buffer_offset         <= rd_data[OFFSET_W-1:0];
            take_index[cur_peer]  <= tk_idx_next;
            if (tk_wrap) begin
              take_phase[cur_peer] <= !take_phase[cur_peer];
            end
          end else begin
            status        <= ST_EMPTY;
            buffer_offset <= '0;
          end
        end
        S_FILL: begin
          fill_slot  <= SLOT_W'(fill_slot + 1'b1);
          fill_value <= OFFSET_W'(fill_value + OFFSET_W'(buffer_bytes));
          if (fill_last) begin
            state         <= S_IDLE;
            status        <= ST_OK;
            buffer_offset <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/free_buffer_ring_with_phase_bit.sv
// take reads the slot, then compares its phase bit; return writes the slot; restart fills
//   one slot a cycle, n slots where n is buffer_count capped at RING_SLOTS; restart on a
//   disabled ring and rejected items load the result directly; a new item starts only when
//   the engine is idle and its result register is free
// reset: indices and take phases clear, return phases set, queue and result empty;
//   slot memory is not cleared; the block has no check, the user must restart each peer before use
// ----------------------------------------------------------------------------
// free_buffer_ring_with_phase_bit
// per-peer rings of free buffer offsets with a phase bit in each slot
// ----------------------------------------------------------------------------
`default_nettype none

module free_buffer_ring_with_phase_bit #(
  parameter int PEERS      = 8,
  parameter int RING_SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [frbp_pkg::BYTES_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    op,
  input  wire logic [frbp_pkg::PEER_IN_W-1:0] peer,
  input  wire logic [frbp_pkg::BYTES_W-1:0]  msg_bytes,
  input  wire logic [frbp_pkg::OFFSET_W-1:0] return_offset,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [frbp_pkg::OFFSET_W-1:0]      buffer_offset
);
  import frbp_pkg::*;

  logic [COUNT_W-1:0] buffer_count;
  logic [BYTES_W-1:0] buffer_bytes;
  cmd_t               front_cmd;
  cmd_t               queue_cmd;
  logic               queue_valid;
  logic               queue_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count <= COUNT_W'(16);
      buffer_bytes <= BYTES_W'(16384);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_COUNT: buffer_count <= cfg_data[COUNT_W-1:0];
        REG_BUFFER_BYTES: buffer_bytes <= cfg_data;
        default: buffer_count <= buffer_count;
      endcase
    end
  end

  frbp_front #(
    .PEERS      (PEERS),
    .RING_SLOTS (RING_SLOTS)
  ) u_front (
    .op            (op),
    .peer          (peer),
    .msg_bytes     (msg_bytes),
    .return_offset (return_offset),
    .buffer_count  (buffer_count),
    .buffer_bytes  (buffer_bytes),
    .cmd           (front_cmd)
  );

  frbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (queue_valid),
    .pop        (queue_pop),
    .pop_cmd    (queue_cmd)
  );

  frbp_back #(
    .PEERS      (PEERS),
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (queue_cmd),
    .cmd_valid     (queue_valid),
    .cmd_pop       (queue_pop),
    .buffer_count  (buffer_count),
    .buffer_bytes  (buffer_bytes),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .buffer_offset (buffer_offset)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/frbp_checker.sv
// ----------------------------------------------------------------------------
// frbp_checker
// port-level checks on the free buffer ring, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_buffer_ring_with_phase_bit_defines.svh"

module frbp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    status,
  input wire logic [frbp_pkg::OFFSET_W-1:0] buffer_offset
);
  import frbp_pkg::*;

  // items accepted but not yet delivered
  logic [2:0] outstanding;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= 3'(outstanding + {2'b0, in_acc} - {2'b0, out_acc});
    end
  end

  `FRBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(buffer_offset), "result changed while stalled")
  `FRBP_ASSERT_NOW(a_no_invented, out_valid, outstanding != 3'd0, "result without an accepted item")
  `FRBP_ASSERT_NOW(a_bounded, 1'b1, outstanding <= 3'd3, "more items in flight than the block holds")
  `FRBP_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK), buffer_offset == '0, "offset given with a failing status")

endmodule

bind free_buffer_ring_with_phase_bit frbp_checker u_checker (.*);

`default_nettype wire
